// ----- hdl/lcg64rr_pkg.sv -----
// shared types and constants for the 64-bit lcg range random generator
// no dependencies; imported by every module of the block
package lcg64rr_pkg;

	localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
	localparam logic [63:0] LCG_INC = 64'd1442695040888963407;
	localparam int unsigned FRAC_SHIFT = 11;
	localparam int unsigned FRAC_W = 64 - FRAC_SHIFT;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QLVL_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_RAW   = 2'd0,
		OP_FRAC  = 2'd1,
		OP_RANGE = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		KIND_ADVANCE,
		KIND_RANGE,
		KIND_EQUAL,
		KIND_INVALID,
		KIND_NOP
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] range_low;
		logic [31:0] span;
	} req_t;

	typedef struct packed {
		logic                push;
		logic                full;
		logic [QLVL_W-1:0]   level;
	} qstat_t;

endpackage

// ----- hdl/lcg64_range_random_generator.sv -----
// 64-bit lcg random generator with unit-fraction and range mapping
// request channel s_*, result channel m_*, seed write channel cfg_*
// every transfer happens on a rising clk edge with valid and ready both high
// cfg_data (64 bits) loads the seed; the generator state is reloaded at once
// only write the seed while no request is in flight
// s_tuser carries the opcode: 0 raw word, 1 unit fraction, 2 value in range,
// 3 no-op; s_tdata carries range_low and range_high as signed q16.16
// m_tdata carries raw_word, unit_fraction and range_value, m_tuser the invalid flag
// structure: a two-entry queue sits between the request side and the execution side
// the execution side owns one 32x32 multiplier and runs one request at a time;
// no-op, equal or reversed bounds go straight to the result, opcodes 0 and 1 run the
// state update, opcode 2 with a real span also scales (three state multiplies, two scaling ones)
// a stalled receiver holds the result register; the execution side holds one more result and up to two
// more requests are taken into the queue meanwhile, then s_tready drops
// reset clears the queue and output valid and sets the generator state to zero
module lcg64_range_random_generator import lcg64rr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// seed write channel
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [63:0]  cfg_data,      // seed_value [63:0]
	// request channel
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,       // range_low [31:0], range_high [63:32]
	input  logic [1:0]   s_tuser,       // opcode [1:0]
	// result channel
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [151:0] m_tdata,       // raw_word [63:0], unit_fraction [116:64],
	                                    // range_value [148:117], zero fill [151:149]
	output logic [0:0]   m_tuser        // invalid [0]
);

	logic        push;
	req_t        push_req;
	logic        pop;
	logic        head_valid;
	req_t        head_req;
	qstat_t      qstat;
	logic [63:0] out_raw;
	logic [31:0] out_range;
	logic        out_invalid;
	logic        back_busy;

	// the seed register is always writable
	assign cfg_ready = 1'b1;

	// request decode and classification
	lcg64rr_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (qstat.full),
		.push     (push),
		.push_req (push_req)
	);

	// decouples the request side from the multiplier sequencer
	lcg64rr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_req   (push_req),
		.pop        (pop),
		.head_valid (head_valid),
		.head_req   (head_req),
		.stat       (qstat)
	);

	// state update, range scaling and result register
	lcg64rr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_load    (cfg_valid && cfg_ready),
		.cfg_seed    (cfg_data),
		.head_valid  (head_valid),
		.head_req    (head_req),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_raw     (out_raw),
		.out_range   (out_range),
		.out_invalid (out_invalid),
		.busy        (back_busy)
	);

	// unit fraction is the top of the raw word
	assign m_tdata = {3'b000, out_range, out_raw[63:FRAC_SHIFT], out_raw};
	assign m_tuser = out_invalid;

`ifndef SYNTH
	// a reversed-bounds result never carries a value
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[148:117] == 32'd0))
		else $error("invalid result with nonzero range value");

	// fraction field always tracks the raw word
	a_frac_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[116:64] == m_tdata[63:11]))
		else $error("unit fraction does not match raw word");

	// a taken request is held somewhere in the block the next cycle
	a_req_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (qstat.level != '0 || back_busy))
		else $error("accepted request was lost");

	// the queue is never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !qstat.push)
		else $error("queue pushed while full");
`endif

endmodule

// ----- hdl/lcg64rr_front.sv -----
// front end: takes requests and sorts them into work kinds
// depends on lcg64rr_pkg
module lcg64rr_front import lcg64rr_pkg::*; (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // range_low [31:0], range_high [63:32]
	input  logic [1:0]  s_tuser,  // opcode [1:0]
	input  logic        q_full,
	output logic        push,
	output req_t        push_req
);

	logic [31:0] low;
	logic [31:0] high;
	opcode_t     op;

	assign low  = s_tdata[31:0];
	assign high = s_tdata[63:32];
	assign op   = opcode_t'(s_tuser);

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	always_comb begin
		push_req.range_low = low;
		// difference fits 32 bits unsigned whenever low < high
		push_req.span = high - low;
		unique case (op)
			OP_RAW, OP_FRAC: push_req.kind = KIND_ADVANCE;
			OP_RANGE: begin
				priority if ($signed(low) > $signed(high)) push_req.kind = KIND_INVALID;
				else if (low == high) push_req.kind = KIND_EQUAL;
				else push_req.kind = KIND_RANGE;
			end
			default: push_req.kind = KIND_NOP;
		endcase
	end

endmodule

// ----- hdl/lcg64rr_queue.sv -----
// small fifo between front end and execution back end
// depends on lcg64rr_pkg
module lcg64rr_queue import lcg64rr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  req_t   push_req,
	input  logic   pop,
	output logic   head_valid,
	output req_t   head_req,
	output qstat_t stat
);

	req_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QLVL_W-1:0] level_q;
	logic              do_push;
	logic              do_pop;

	assign head_valid = (level_q != '0);
	assign head_req   = mem_q[rd_ptr_q];
	assign do_push    = push && (level_q != QLVL_W'(QUEUE_DEPTH));
	assign do_pop     = pop && head_valid;

	assign stat.push  = do_push;
	assign stat.full  = (level_q == QLVL_W'(QUEUE_DEPTH));
	assign stat.level = level_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

// ----- hdl/lcg64rr_back.sv -----
// back end: generator state, shared 32x32 multiplier sequencer, result register
// depends on lcg64rr_pkg
module lcg64rr_back import lcg64rr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_load,
	input  logic [63:0]        cfg_seed,
	input  logic               head_valid,
	input  req_t               head_req,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [63:0]        out_raw,
	output logic [31:0]        out_range,
	output logic               out_invalid,
	output logic               busy
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_LL,
		ST_MUL_HL,
		ST_MUL_LH,
		ST_UPDATE,
		ST_MUL_SL,
		ST_MUL_SH,
		ST_SCALE,
		ST_EMIT
	} st_t;

	st_t         st_q;
	req_t        item_q;
	logic [63:0] gen_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [31:0] cross_q;
	logic [31:0] res_q;
	logic        inv_q;
	logic        out_valid_q;
	logic [63:0] raw_q;
	logic [31:0] range_q;
	logic        inval_q;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] cross_sum;
	logic [53:0] scale_sum;

	assign pop         = (st_q == ST_IDLE) && head_valid;
	assign busy        = (st_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign out_raw     = raw_q;
	assign out_range   = range_q;
	assign out_invalid = inval_q;

	assign cross_sum = cross_q + prod_q[31:0];
	// part_hi + (part_lo >> 32), offset is bits [52:21]
	assign scale_sum = prod_q[53:0] + {22'd0, acc_q[63:32]};

	always_comb begin
		unique case (st_q)
			ST_MUL_LL: begin
				mul_a = gen_q[31:0];
				mul_b = LCG_MUL[31:0];
			end
			ST_MUL_HL: begin
				mul_a = gen_q[63:32];
				mul_b = LCG_MUL[31:0];
			end
			ST_MUL_LH: begin
				mul_a = gen_q[31:0];
				mul_b = LCG_MUL[63:32];
			end
			ST_MUL_SL: begin
				mul_a = item_q.span;
				mul_b = gen_q[FRAC_SHIFT+31:FRAC_SHIFT];
			end
			ST_MUL_SH: begin
				mul_a = item_q.span;
				mul_b = {{(32-(FRAC_W-32)){1'b0}}, gen_q[63:FRAC_SHIFT+32]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			item_q      <= '0;
			gen_q       <= '0;
			acc_q       <= '0;
			cross_q     <= '0;
			res_q       <= '0;
			inv_q       <= 1'b0;
			out_valid_q <= 1'b0;
			raw_q       <= '0;
			range_q     <= '0;
			inval_q     <= 1'b0;
		end else begin
			// the emit state drives valid itself
			if (out_ready && st_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (head_valid) begin
						item_q <= head_req;
						res_q  <= (head_req.kind == KIND_EQUAL) ? head_req.range_low : '0;
						inv_q  <= (head_req.kind == KIND_INVALID);
						if (head_req.kind == KIND_ADVANCE || head_req.kind == KIND_RANGE) begin
							st_q <= ST_MUL_LL;
						end else begin
							st_q <= ST_EMIT;
						end
					end
				end
				ST_MUL_LL: st_q <= ST_MUL_HL;
				ST_MUL_HL: begin
					acc_q <= prod_q;
					st_q  <= ST_MUL_LH;
				end
				ST_MUL_LH: begin
					cross_q <= prod_q[31:0];
					st_q    <= ST_UPDATE;
				end
				ST_UPDATE: begin
					gen_q <= acc_q + {cross_sum, 32'd0} + LCG_INC;
					st_q  <= (item_q.kind == KIND_RANGE) ? ST_MUL_SL : ST_EMIT;
				end
				ST_MUL_SL: st_q <= ST_MUL_SH;
				ST_MUL_SH: begin
					acc_q <= prod_q;
					st_q  <= ST_SCALE;
				end
				ST_SCALE: begin
					res_q <= item_q.range_low + scale_sum[52:21];
					st_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						raw_q       <= gen_q;
						range_q     <= res_q;
						inval_q     <= inv_q;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			// seed writes must only arrive while idle; the block itself does not enforce it
			if (cfg_load) begin
				gen_q <= cfg_seed;
			end
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for lcg64_range_random_generator
// drives request and seed channels, predicts every draw and checks the result stream
// depends on lcg64rr_pkg and the rtl of the block only
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lcg64rr_pkg::*;

	// recurrence constants of the 64-bit generator
	localparam logic [63:0] STEP_MUL = 64'd6364136223846793005;
	localparam logic [63:0] STEP_ADD = 64'd1442695040888963407;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam int DRAIN_CYCLES = 16;     // longer than the slowest request latency
	localparam int HOLD_CYCLES = 200;     // long receiver hold-off
	localparam int PHASE_ITEMS = 322;

	// one expected result transfer
	typedef struct packed {
		logic [63:0]        raw_word;
		logic [52:0]        unit_fraction;
		logic signed [31:0] range_value;
		logic               invalid;
	} draw_t;

	// keeps its own copy of the generator state and the draws still owed
	class draw_scoreboard;
		logic [63:0] gen_state;
		draw_t       owed_draws[$];
		int          errors;

		function new();
			gen_state = '0;
			errors = 0;
		endfunction

		function void load_seed(logic [63:0] seed);
			gen_state = seed;
		endfunction

		function int outstanding();
			return owed_draws.size();
		endfunction

		// works out the draw caused by one accepted request
		function void note_request(opcode_t op, logic signed [31:0] lo, logic signed [31:0] hi);
			draw_t       d;
			logic [32:0] span;
			logic [84:0] prod;
			d = '0;
			case (op)
				OP_RAW, OP_FRAC: begin
					gen_state = gen_state * STEP_MUL + STEP_ADD;
				end
				OP_RANGE: begin
					if (lo > hi) begin
						// reversed bounds: flag only, state kept
						d.invalid = 1'b1;
					end else if (lo == hi) begin
						// equal bounds: low bound back, state kept
						d.range_value = lo;
					end else begin
						gen_state = gen_state * STEP_MUL + STEP_ADD;
						span = {hi[31], hi} - {lo[31], lo};
						// exact product, floor of the 53-bit shift
						prod = 85'(span[31:0]) * 85'(gen_state[63:11]);
						d.range_value = lo + prod[84:53];
					end
				end
				default: ;
			endcase
			d.raw_word = gen_state;
			d.unit_fraction = gen_state[63:11];
			owed_draws.insert(owed_draws.size(), d);
		endfunction

		function void compare(string field, logic [63:0] exp_val, logic [63:0] act_val);
			if (exp_val !== act_val) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $realtime, field,
					exp_val, act_val);
			end
		endfunction

		// checks one result transfer against the oldest owed draw
		function void check_draw(logic [151:0] data, logic [0:0] flags);
			draw_t d;
			if (owed_draws.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h / %b", $realtime,
					data, flags);
				return;
			end
			d = owed_draws.pop_front();
			compare("raw_word", d.raw_word, data[63:0]);
			compare("unit_fraction", 64'(d.unit_fraction), 64'(data[116:64]));
			compare("range_value", 64'(d.range_value[31:0]), 64'(data[148:117]));
			compare("invalid", 64'(d.invalid), 64'(flags[0]));
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [63:0]  cfg_data;        // seed_value [63:0]
	logic         s_tvalid;
	logic         s_tready;
	logic [63:0]  s_tdata;         // range_low [31:0], range_high [63:32]
	logic [1:0]   s_tuser;         // opcode [1:0]
	logic         m_tvalid;
	logic         m_tready;
	logic [151:0] m_tdata;         // raw_word [63:0], unit_fraction [116:64],
	                               // range_value [148:117], zero fill [151:149]
	logic [0:0]   m_tuser;         // invalid [0]

	draw_scoreboard sb;

	// sender pacing state
	int burst_left = 0;
	bit gaps_off = 1'b0;
	// receiver hold-off request from the stimulus process
	bit hold_req = 1'b0;

	always #4 clk = ~clk;

	lcg64_range_random_generator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// offers one request, waits for its transfer, then paces the next one
	task automatic send_item(opcode_t op, logic signed [31:0] lo, logic signed [31:0] hi);
		s_tuser <= op;
		s_tdata <= {hi, lo};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, lo, hi);
		// bursts of random length, random gaps between them
		if (gaps_off || burst_left > 0) begin
			if (burst_left > 0)
				burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end
	endtask

	// sender pause until every owed draw has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// seed write, only issued while the block is idle
	task automatic write_seed(logic [63:0] seed);
		cfg_data <= seed;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.load_seed(seed);
		cfg_valid <= 1'b0;
	endtask

	// bounds for a range request: mostly well-ordered, some equal, reversed or extreme
	function automatic void pick_bounds(output logic signed [31:0] lo,
		output logic signed [31:0] hi);
		logic signed [31:0] a, b, t;
		logic signed [31:0] corner[5];
		int mode;
		corner = '{Q_MIN, -32'sd1, 32'sd0, 32'sd1, Q_MAX};
		a = $urandom;
		b = $urandom;
		mode = $urandom_range(0, 99);
		if (mode < 45) begin
			if (a > b) begin
				t = a; a = b; b = t;
			end
		end else if (mode < 65) begin
			// narrow span; a wrap past the top turns into reversed bounds
			b = a + 32'($urandom_range(1, 1 << $urandom_range(0, 20)));
		end else if (mode < 72) begin
			b = a;
		end else if (mode < 82) begin
			if (a < b) begin
				t = a; a = b; b = t;
			end
		end else if (mode < 92) begin
			a = corner[$urandom_range(0, 4)];
			b = corner[$urandom_range(0, 4)];
		end
		lo = a;
		hi = b;
	endfunction

	task automatic send_random();
		opcode_t op;
		logic signed [31:0] lo, hi;
		int pick;
		pick = $urandom_range(0, 99);
		lo = $urandom;
		hi = $urandom;
		if (pick < 25)
			op = OP_RAW;
		else if (pick < 40)
			op = OP_FRAC;
		else if (pick < 90) begin
			op = OP_RANGE;
			pick_bounds(lo, hi);
		end else
			op = OP_NONE;
		send_item(op, lo, hi);
	endtask

	// receiver: checks each result transfer, then sets the next ready value
	initial begin : result_side
		int cycle_cnt;
		int hold_left;
		int rx_mode;
		cycle_cnt = 0;
		hold_left = 0;
		rx_mode = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_draw(m_tdata, m_tuser);
			cycle_cnt++;
			if (cycle_cnt % 97 == 0)
				rx_mode = $urandom_range(0, 3);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0: m_tready <= 1'b1;                          // no stalls
					1: m_tready <= 1'($urandom_range(0, 1));      // coin toss
					2: m_tready <= (cycle_cnt % 4 == 0);          // one in four
					default: m_tready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// stimulus
	initial begin : request_side
		logic [63:0] seeds[6];
		sb = new();
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_NONE;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, generator still at its reset state
		send_item(OP_RAW, 32'sd0, 32'sd0);
		send_item(OP_FRAC, 32'sd0, 32'sd0);
		send_item(OP_NONE, -32'sd1, -32'sd1);
		send_item(OP_RANGE, 32'sd0, 32'sd0);               // equal bounds at zero
		send_item(OP_RANGE, Q_MAX, Q_MAX);                 // equal bounds at the top
		send_item(OP_RANGE, Q_MIN, Q_MIN);                 // equal bounds at the bottom
		send_item(OP_RANGE, Q_MAX, Q_MIN);                 // reversed, widest
		send_item(OP_RANGE, 32'sd1, 32'sd0);               // reversed by one
		send_item(OP_RANGE, Q_MIN, Q_MAX);                 // full span
		send_item(OP_RANGE, Q_MIN, Q_MIN + 32'sd1);
		send_item(OP_RANGE, Q_MAX - 32'sd1, Q_MAX);
		send_item(OP_RANGE, 32'sd0, 32'sd1);
		send_item(OP_RANGE, -32'sd1, 32'sd0);
		send_item(OP_RANGE, 32'sh0001_0000, 32'sh0002_0000);
		send_item(OP_RANGE, -32'sh0001_0000, 32'sh7FFF_0000);
		send_item(OP_RANGE, 32'sd0, Q_MAX);
		send_item(OP_RANGE, Q_MIN, 32'sd0);
		send_item(OP_RAW, -32'sd1, -32'sd1);
		send_item(OP_FRAC, Q_MIN, Q_MAX);
		send_item(OP_NONE, 32'sd0, 32'sd0);
		send_item(OP_NONE, Q_MIN, Q_MAX);
		wait_drained();

		// random phases, one seed each, extremes included
		seeds[0] = '1;
		seeds[1] = '0;
		seeds[2] = 64'd1;
		seeds[3] = {$urandom, $urandom};
		seeds[4] = 64'h8000_0000_0000_0000;
		seeds[5] = {$urandom, $urandom};
		for (int p = 0; p < 6; p++) begin
			write_seed(seeds[p]);
			if (p == 1 || p == 4) begin
				// receiver holds off while requests keep coming: the block backs up
				hold_req = 1'b1;
				gaps_off = 1'b1;
				repeat (20) send_random();
				gaps_off = 1'b0;
			end
			repeat (PHASE_ITEMS) send_random();
			wait_drained();
		end

		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// run limit
	initial begin : watchdog
		#4ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
